// ===== rtl/core/ile_pkg.sv =====
// shared constants, types and helpers for the ising lattice energy store
// no dependencies; imported by every module of the block
`default_nettype none

package ile_pkg;

    // lattice limits and derived widths
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int DIM_W      = 7;
    localparam int IDX_MAX_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int CW         = ((IDX_MAX_W > DIM_W) ? IDX_MAX_W : DIM_W) + 1;

    // field widths
    localparam int REQ_W      = 2;
    localparam int POS_W      = 6;
    localparam int ENERGY_W   = 14;
    localparam int ENERGY_MAX = 8191;
    localparam int ENERGY_MIN = -8192;
    localparam int ACC_W      = $clog2(2 * MAX_WIDTH * MAX_HEIGHT + 1) + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SITE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TOTAL = 2'd2;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // read operand codes carried with each memory read
    localparam logic [1:0] OP_SITE_ME = 2'd0;
    localparam logic [1:0] OP_SITE_NB = 2'd1;
    localparam logic [1:0] OP_WALK_ME = 2'd2;
    localparam logic [1:0] OP_WALK_UP = 2'd3;

    // result kinds
    localparam logic [1:0] LD_NONE  = 2'd0;
    localparam logic [1:0] LD_SITE  = 2'd1;
    localparam logic [1:0] LD_TOTAL = 2'd2;

    typedef struct packed {
        logic       vld;
        logic [1:0] op;
        logic       incl;
    } t_rd_tag;

    typedef struct packed {
        logic       clr;
        logic       ld;
        logic [1:0] kind;
    } t_acc_ctl;

    // dimension as used: zero reads as one, clipped to the lattice limit
    function automatic logic [DIM_W-1:0] used_dim(input logic [DIM_W-1:0] dim, input int lim);
        logic [DIM_W-1:0] res;
        if (dim == '0) begin
            res = DIM_W'(1);
        end else if (int'(dim) > lim) begin
            res = DIM_W'(lim);
        end else begin
            res = dim;
        end
        return res;
    endfunction

    // fixed cell address r * MAX_WIDTH + c
    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ile_spin_ram.sv =====
// spin memory: one bit per site, one write and one registered read port
// depends on ile_pkg for depth and address width
`default_nettype none

module ile_spin_ram (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire  [ile_pkg::ADDR_W-1:0] i_waddr,
    input  wire                        i_wdata,
    input  wire                        i_re,
    input  wire  [ile_pkg::ADDR_W-1:0] i_raddr,
    output logic                       o_rdata
);
    import ile_pkg::*;

    logic r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ile_seq.sv =====
// request sequencer: config registers, spin writes, read address walk
// depends on ile_pkg; drives ile_spin_ram and ile_accum
`default_nettype none

module ile_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // request word
    input  wire                          i_req_valid,
    output logic                         o_req_ready,
    input  wire  [ile_pkg::REQ_W-1:0]    i_req_type,
    input  wire  [ile_pkg::POS_W-1:0]    i_row,
    input  wire  [ile_pkg::POS_W-1:0]    i_col,
    input  wire                          i_new_spin,
    // configuration writes
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire                          i_cfg_addr,
    input  wire  [ile_pkg::DIM_W-1:0]    i_cfg_data,
    // memory ports
    output logic                         o_we,
    output logic [ile_pkg::ADDR_W-1:0]   o_waddr,
    output logic                         o_wdata,
    output logic                         o_re,
    output logic [ile_pkg::ADDR_W-1:0]   o_raddr,
    // accumulator control
    output ile_pkg::t_rd_tag             o_tag,
    output ile_pkg::t_acc_ctl            o_ctl,
    input  wire                          i_out_free
);
    import ile_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SITE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [2:0] ST_ME = 3'd0;
    localparam logic [2:0] ST_UP = 3'd1;
    localparam logic [2:0] ST_DN = 3'd2;
    localparam logic [2:0] ST_LF = 3'd3;
    localparam logic [2:0] ST_RT = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_step,  n_step;
    logic [1:0]       r_kind,  n_kind;
    logic [ROW_W-1:0] r_r,     n_r;
    logic [COL_W-1:0] r_c,     n_c;
    logic             r_ph,    n_ph;
    logic [DIM_W-1:0] r_gw,    r_gh;

    logic [DIM_W-1:0] w_use, h_use;
    logic             accept, in_grid;
    logic [ROW_W-1:0] nb_r;
    logic [COL_W-1:0] nb_c;
    logic             nb_incl;
    logic [1:0]       nb_op;
    logic             last_col, last_row;

    assign w_use = used_dim(r_gw, MAX_WIDTH);
    assign h_use = used_dim(r_gh, MAX_HEIGHT);

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign in_grid     = (CW'(i_row) < CW'(h_use)) && (CW'(i_col) < CW'(w_use));

    // config registers, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= DIM_W'(64);
            r_gh <= DIM_W'(64);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_WIDTH:  r_gw <= i_cfg_data;
                CFG_HEIGHT: r_gh <= i_cfg_data;
                default:    r_gw <= r_gw;
            endcase
        end
    end

    // spin write straight from the request word
    assign o_we    = accept && (i_req_type == REQ_WRITE) && in_grid;
    assign o_waddr = addr_of(ROW_W'(i_row), COL_W'(i_col));
    assign o_wdata = i_new_spin;

    // end of row and end of lattice during the walk
    assign last_col = (CW'(r_c) + CW'(1)) == CW'(w_use);
    assign last_row = (CW'(r_r) + CW'(1)) == CW'(h_use);

    // neighbor coordinates for the current read
    always_comb begin
        nb_r    = r_r;
        nb_c    = r_c;
        nb_incl = 1'b1;
        nb_op   = OP_SITE_NB;
        if (r_state == S_WALK) begin
            if (!r_ph) begin
                nb_op   = OP_WALK_ME;
                nb_incl = (r_c != '0);
            end else begin
                nb_op   = OP_WALK_UP;
                nb_incl = (r_r != '0);
                nb_r    = r_r - ROW_W'(1);
            end
        end else begin
            case (r_step)
                ST_ME: begin
                    nb_op = OP_SITE_ME;
                end
                ST_UP: begin
                    nb_incl = (r_r != '0);
                    nb_r    = r_r - ROW_W'(1);
                end
                ST_DN: begin
                    nb_incl = (CW'(r_r) + CW'(1)) < CW'(h_use);
                    nb_r    = r_r + ROW_W'(1);
                end
                ST_LF: begin
                    nb_incl = (r_c != '0);
                    nb_c    = r_c - COL_W'(1);
                end
                ST_RT: begin
                    nb_incl = (CW'(r_c) + CW'(1)) < CW'(w_use);
                    nb_c    = r_c + COL_W'(1);
                end
                default: begin
                    nb_incl = 1'b0;
                end
            endcase
        end
    end

    // read issue; an excluded neighbor reads the site itself
    assign o_re      = (r_state == S_SITE) || (r_state == S_WALK);
    assign o_raddr   = (nb_incl && !(r_state == S_WALK && !r_ph))
                       ? addr_of(nb_r, nb_c) : addr_of(r_r, r_c);
    assign o_tag.vld  = o_re;
    assign o_tag.op   = nb_op;
    assign o_tag.incl = nb_incl;

    // sequencing
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_kind     = r_kind;
        n_r        = r_r;
        n_c        = r_c;
        n_ph       = r_ph;
        o_ctl.clr  = 1'b0;
        o_ctl.ld   = 1'b0;
        o_ctl.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_r    = ROW_W'(i_row);
                    n_c    = COL_W'(i_col);
                    n_step = ST_ME;
                    n_ph   = 1'b0;
                    case (i_req_type)
                        REQ_SITE: begin
                            o_ctl.clr = 1'b1;
                            n_kind    = in_grid ? LD_SITE : LD_NONE;
                            n_state   = in_grid ? S_SITE : S_DONE;
                        end
                        REQ_TOTAL: begin
                            o_ctl.clr = 1'b1;
                            n_kind    = LD_TOTAL;
                            n_r       = '0;
                            n_c       = '0;
                            n_state   = S_WALK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SITE: begin
                n_step = r_step + 3'd1;
                if (r_step == ST_RT) begin
                    n_state = S_DRAIN;
                end
            end
            S_WALK: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    if (last_col) begin
                        n_c = '0;
                        n_r = r_r + ROW_W'(1);
                        if (last_row) begin
                            n_state = S_DRAIN;
                        end
                    end else begin
                        n_c = r_c + COL_W'(1);
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_ctl.ld = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_ME;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ph    <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_r    <= n_r;
        r_c    <= n_c;
    end

endmodule

`default_nettype wire

// ===== rtl/core/ile_accum.sv =====
// energy accumulation on returned spins and the result output register
// depends on ile_pkg for tag and control structs
`default_nettype none

module ile_accum (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  ile_pkg::t_rd_tag                 i_tag,
    input  wire                              i_rdata,
    input  ile_pkg::t_acc_ctl                i_ctl,
    output logic                             o_out_free,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic                             o_site_spin,
    output logic signed [ile_pkg::ENERGY_W-1:0] o_energy,
    output logic                             o_was_total
);
    import ile_pkg::*;

    t_rd_tag                    r_tag;
    logic                       r_me, r_left;
    logic signed [3:0]          r_sum;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_vld;
    logic                       r_spin, r_total;
    logic signed [ENERGY_W-1:0] r_energy;

    logic signed [ENERGY_W-1:0] site_e;
    logic signed [31:0]         acc_ext;
    logic signed [ENERGY_W-1:0] tot_e;

    // tag is registered so that it lines up with the registered memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // neighbor sum and bond accumulation
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
            r_acc <= '0;
        end else if (r_tag.vld) begin
            case (r_tag.op)
                OP_SITE_ME: begin
                    r_me <= i_rdata;
                end
                OP_SITE_NB: begin
                    if (r_tag.incl) begin
                        r_sum <= i_rdata ? r_sum + 4'sd1 : r_sum - 4'sd1;
                    end
                end
                OP_WALK_ME: begin
                    if (r_tag.incl) begin
                        r_acc <= (i_rdata == r_left) ? r_acc - ACC_W'(1) : r_acc + ACC_W'(1);
                    end
                    r_left <= i_rdata;
                    r_me   <= i_rdata;
                end
                OP_WALK_UP: begin
                    if (r_tag.incl) begin
                        r_acc <= (i_rdata == r_me) ? r_acc - ACC_W'(1) : r_acc + ACC_W'(1);
                    end
                end
                default: begin
                    r_me <= r_me;
                end
            endcase
        end
    end

    // local energy is minus spin times neighbor sum
    assign site_e  = r_me ? -ENERGY_W'(r_sum) : ENERGY_W'(r_sum);

    // total saturates to the output range
    assign acc_ext = 32'(r_acc);
    always_comb begin
        if (acc_ext > ENERGY_MAX) begin
            tot_e = ENERGY_W'(ENERGY_MAX);
        end else if (acc_ext < ENERGY_MIN) begin
            tot_e = ENERGY_W'(ENERGY_MIN);
        end else begin
            tot_e = ENERGY_W'(acc_ext);
        end
    end

    // output register
    assign o_out_free = !r_vld || i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.ld) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            case (i_ctl.kind)
                LD_SITE: begin
                    r_spin   <= r_me;
                    r_energy <= site_e;
                    r_total  <= 1'b0;
                end
                LD_TOTAL: begin
                    r_spin   <= 1'b0;
                    r_energy <= tot_e;
                    r_total  <= 1'b1;
                end
                default: begin
                    r_spin   <= 1'b0;
                    r_energy <= '0;
                    r_total  <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid     = r_vld;
    assign o_site_spin = r_spin;
    assign o_energy    = r_energy;
    assign o_was_total = r_total;

endmodule

`default_nettype wire

// ===== rtl/core/ising_lattice_energy_store_top.sv =====
// Ising lattice energy store, top level.
// Channels: request words on s_axis (tuser = request type, tdata = row, col, new spin),
// results on m_axis (tuser = total flag, tdata = site spin, energy), and a config
// write channel (index 0 grid width, index 1 grid height), always ready.
// A spin write gives no result. A site query reads the site and its four neighbors
// through the single read port of the spin memory, one per cycle. A query of a
// site outside the lattice reads no memory. A total query walks the lattice in
// raster order with two reads per site (the site and the one above, the left
// neighbor is held in a register).
// One request is in work at a time; a new request is taken as soon as the
// previous one has moved its result into the output register, even while that
// result waits for m_axis_tready. A stalled output holds the finished query.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, empties the
// output register and sets both dimensions to 64; the spin memory is not cleared
// and every site must be written before it is queried.
// depends on ile_pkg, ile_spin_ram, ile_seq, ile_accum
`default_nettype none

module ising_lattice_energy_store_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // row[5:0], col[11:6], new_spin[12], zero[15:13]
    input  wire  [1:0]  s_axis_tuser,   // req_type[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // site_spin[0], energy[14:1], zero[15]
    output logic [0:0]  m_axis_tuser,   // was_total[0]
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_addr,
    input  wire  [6:0]  i_cfg_data
);
    import ile_pkg::*;

    logic                       we, re, wdata, rdata, out_free;
    logic [ADDR_W-1:0]          waddr, raddr;
    t_rd_tag                    tag;
    t_acc_ctl                   ctl;
    logic                       site_spin, was_total;
    logic signed [ENERGY_W-1:0] energy;

    // request sequencing and config registers
    ile_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .i_row       (s_axis_tdata[5:0]),
        .i_col       (s_axis_tdata[11:6]),
        .i_new_spin  (s_axis_tdata[12]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_tag       (tag),
        .o_ctl       (ctl),
        .i_out_free  (out_free)
    );

    // spin memory
    ile_spin_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // energy accumulation and output register
    ile_accum u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (tag),
        .i_rdata     (rdata),
        .i_ctl       (ctl),
        .o_out_free  (out_free),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_site_spin (site_spin),
        .o_energy    (energy),
        .o_was_total (was_total)
    );

    // result word packing
    assign m_axis_tdata = {1'b0, energy, site_spin};
    assign m_axis_tuser = was_total;

endmodule

`default_nettype wire

// ===== bench/ising_lattice_energy_store_top_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for ising_lattice_energy_store_top: random and directed requests,
// energies predicted from a local copy of the spin lattice and dimensions
// depends on ile_pkg and the ising_lattice_energy_store_top rtl
module ising_lattice_energy_store_top_test;

    import ile_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 3_000_000;
    localparam int         HOLD_CYCLES = 600;
    localparam int         SETTLE      = 16;
    localparam int         PHASES      = 14;
    localparam int         PHASE_ITEMS = 32;
    localparam int         PRESSURE_PH = 7;
    localparam int         ALIGN_DIM   = 8;

    typedef struct {
        logic [1:0]       kind;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             spin;
    } t_lattice_request;

    typedef struct {
        logic                       site_spin;
        logic signed [ENERGY_W-1:0] energy;
        logic                       was_total;
    } t_energy_result;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // row[5:0], col[11:6], new_spin[12], zero[15:13]
    logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // site_spin[0], energy[14:1], zero[15]
    logic [0:0]  m_axis_tuser;        // was_total[0]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_addr = 1'b0;
    logic [6:0]  i_cfg_data = '0;

    // local copy of the lattice and dimension registers
    bit         lattice_spin [MAX_HEIGHT][MAX_WIDTH];
    bit         site_written [MAX_HEIGHT][MAX_WIDTH];
    logic [6:0] width_reg  = 7'd64;
    logic [6:0] height_reg = 7'd64;

    t_lattice_request request_queue[$];
    t_energy_result   expected_energies[$];
    int               queued_count   = 0;
    int               accepted_count = 0;
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    int               gap_left       = 0;
    int               stall_left     = 0;
    int               hold_left      = 0;
    bit               hold_done      = 1'b0;
    bit               hold_arm       = 1'b0;
    bit               sender_idle    = 1'b0;
    bit               receiver_idle  = 1'b0;

    ising_lattice_energy_store_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // zero reads as one, anything above the limit is clipped
    function automatic int dim_in_effect(input logic [6:0] value, input int limit);
        if (value == 7'd0) return 1;
        if (int'(value) > limit) return limit;
        return int'(value);
    endfunction

    function automatic int spin_value(input int r, input int c);
        return lattice_spin[r][c] ? 1 : -1;
    endfunction

    function automatic logic signed [ENERGY_W-1:0] clamp_energy(input int e);
        if (e > ENERGY_MAX) e = ENERGY_MAX;
        if (e < ENERGY_MIN) e = ENERGY_MIN;
        return ENERGY_W'(e);
    endfunction

    // mostly no pause, some short ones, a few long ones
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // update the lattice copy and queue the energy a query must return
    task automatic apply_request(input logic [1:0] kind, input logic [15:0] word);
        int w, h, r, c, me, sum, total, i, j;
        t_energy_result res;
        w = dim_in_effect(width_reg, MAX_WIDTH);
        h = dim_in_effect(height_reg, MAX_HEIGHT);
        r = int'(word[5:0]);
        c = int'(word[11:6]);
        if (kind == REQ_WRITE) begin
            if (r < h && c < w) lattice_spin[r][c] = word[12];
        end else if (kind == REQ_SITE) begin
            res.was_total = 1'b0;
            if (r >= h || c >= w) begin
                res.site_spin = 1'b0;
                res.energy    = '0;
            end else begin
                me  = spin_value(r, c);
                sum = 0;
                if (r > 0)     sum += spin_value(r - 1, c);
                if (r + 1 < h) sum += spin_value(r + 1, c);
                if (c > 0)     sum += spin_value(r, c - 1);
                if (c + 1 < w) sum += spin_value(r, c + 1);
                res.site_spin = lattice_spin[r][c];
                res.energy    = clamp_energy(-(me * sum));
            end
            expected_energies.push_back(res);
        end else if (kind == REQ_TOTAL) begin
            total = 0;
            for (i = 0; i < h; i++) begin
                for (j = 0; j < w; j++) begin
                    if (j + 1 < w) total -= spin_value(i, j) * spin_value(i, j + 1);
                    if (i + 1 < h) total -= spin_value(i, j) * spin_value(i + 1, j);
                end
            end
            res.site_spin = 1'b0;
            res.energy    = clamp_energy(total);
            res.was_total = 1'b1;
            expected_energies.push_back(res);
        end
    endtask

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : sender
        t_lattice_request item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(s_axis_tuser, s_axis_tdata);
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    s_axis_tvalid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end else if (request_queue.size() != 0) begin
                    item = request_queue.pop_front();
                    s_axis_tdata  <= {3'b000, item.spin, item.col, item.row};
                    s_axis_tuser  <= item.kind;
                    s_axis_tvalid <= 1'b1;
                    gap_left      <= sender_idle ? idle_length() : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin : receiver
        t_energy_result want, got;
        int pause;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.site_spin = m_axis_tdata[0];
                got.energy    = m_axis_tdata[14:1];
                got.was_total = m_axis_tuser[0];
                if (expected_energies.size() == 0) begin
                    $display("%0t ns: word with none expected, actual energy %0d total %0d",
                             $time, got.energy, got.was_total);
                    mismatch_count++;
                end else begin
                    want = expected_energies.pop_front();
                    compare_field("site_spin", want.site_spin, got.site_spin);
                    compare_field("energy", want.energy, got.energy);
                    compare_field("was_total", want.was_total, got.was_total);
                end
            end
            if (stall_left != 0) begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                pause = receiver_idle ? idle_length() : 0;
                stall_left    <= pause;
                m_axis_tready <= (pause == 0) && (hold_left == 0);
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // run time limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ising_lattice_energy_store_top verification failed");
            $finish;
        end
    end

    task automatic queue_request(input logic [1:0] kind, input int row, input int col,
                                 input bit spin);
        t_lattice_request item;
        item.kind = kind;
        item.row  = POS_W'(row);
        item.col  = POS_W'(col);
        item.spin = spin;
        request_queue.push_back(item);
        queued_count++;
    endtask

    // write every site of the w x h lattice that has not been written yet
    task automatic fill_lattice(input int w, input int h, input bit random_spin);
        int r, c;
        for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
                if (!site_written[r][c]) begin
                    if (random_spin) queue_request(REQ_WRITE, r, c, $urandom_range(0, 1));
                    else queue_request(REQ_WRITE, r, c, 1'b1);
                    site_written[r][c] = 1'b1;
                end
            end
        end
    endtask

    // mostly in-lattice requests leaning toward edges, some anywhere
    task automatic queue_random_request(input int w, input int h, input bit allow_total);
        int roll, row, col;
        logic [1:0] kind;
        roll = $urandom_range(0, 99);
        if (roll < 5) kind = REQ_UNUSED;
        else if (roll < 45) kind = REQ_WRITE;
        else if (roll < 92 || !allow_total) kind = REQ_SITE;
        else kind = REQ_TOTAL;
        if ($urandom_range(0, 9) == 0) begin
            row = $urandom_range(0, 63);
            col = $urandom_range(0, 63);
        end else begin
            row = $urandom_range(0, h - 1);
            col = $urandom_range(0, w - 1);
            if ($urandom_range(0, 3) == 0) row = $urandom_range(0, 1) ? 0 : h - 1;
            if ($urandom_range(0, 3) == 0) col = $urandom_range(0, 1) ? 0 : w - 1;
        end
        queue_request(kind, row, col, $urandom_range(0, 1));
    endtask

    task automatic write_register(input logic idx, input logic [6:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) width_reg = value;
        else height_reg = value;
    endtask

    // every word taken, every result back, then let the block settle
    task automatic wait_for_drain();
        while (accepted_count != queued_count || expected_energies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int phase_w [PHASES];
        int phase_h [PHASES];
        int p, n, w, h, wv, hv;
        bit allow_total;
        phase_w = '{1, 1, 64, 0, 2, 127, 65, 8, 5, 16, 3, -1, -1, 40};
        phase_h = '{1, 64, 1, 0, 2, 2, 3, 8, 3, 12, 70, -1, -1, 6};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // dimensions out of reset: right edge of the top row, no idling
        queue_request(REQ_WRITE, 0, 62, 1'b1);
        queue_request(REQ_WRITE, 0, 63, 1'b0);
        queue_request(REQ_WRITE, 1, 63, 1'b1);
        site_written[0][62] = 1'b1;
        site_written[0][63] = 1'b1;
        site_written[1][63] = 1'b1;
        queue_request(REQ_SITE, 0, 63, 1'b0);
        wait_for_drain();

        // small lattice filled with +1
        write_register(CFG_WIDTH, 7'(ALIGN_DIM));
        write_register(CFG_HEIGHT, 7'(ALIGN_DIM));
        fill_lattice(ALIGN_DIM, ALIGN_DIM, 1'b0);
        wait_for_drain();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;

        // aligned lattice: lowest total, corner, edge and interior sites
        queue_request(REQ_TOTAL, 0, 0, 1'b0);
        queue_request(REQ_SITE, 0, 0, 1'b0);
        queue_request(REQ_SITE, 0, ALIGN_DIM - 1, 1'b1);
        queue_request(REQ_SITE, ALIGN_DIM - 1, 0, 1'b0);
        queue_request(REQ_SITE, ALIGN_DIM - 1, ALIGN_DIM - 1, 1'b1);
        queue_request(REQ_SITE, 0, 3, 1'b0);
        queue_request(REQ_SITE, 3, 3, 1'b0);
        // flipped spins and their neighbors
        queue_request(REQ_WRITE, 3, 3, 1'b0);
        queue_request(REQ_SITE, 3, 3, 1'b1);
        queue_request(REQ_SITE, 3, 4, 1'b0);
        queue_request(REQ_WRITE, ALIGN_DIM - 1, ALIGN_DIM - 1, 1'b0);
        queue_request(REQ_SITE, ALIGN_DIM - 1, ALIGN_DIM - 1, 1'b0);
        queue_request(REQ_SITE, ALIGN_DIM - 2, ALIGN_DIM - 1, 1'b1);
        // unused request code with every bit set, must be dropped
        queue_request(REQ_UNUSED, 63, 63, 1'b1);
        queue_request(REQ_TOTAL, 63, 63, 1'b1);
        wait_for_drain();

        // dimension phases: ones, full, zero, above range and random small
        for (p = 0; p < PHASES; p++) begin
            wv = (phase_w[p] < 0) ? $urandom_range(1, 16) : phase_w[p];
            hv = (phase_h[p] < 0) ? $urandom_range(1, 16) : phase_h[p];
            write_register(CFG_WIDTH, 7'(wv));
            write_register(CFG_HEIGHT, 7'(hv));
            w = dim_in_effect(width_reg, MAX_WIDTH);
            h = dim_in_effect(height_reg, MAX_HEIGHT);
            allow_total   = (w * h <= 256);
            receiver_idle = (p % 4 != 2);
            if (p == PRESSURE_PH) begin
                sender_idle = 1'b0;
                hold_arm    = 1'b1;
            end
            fill_lattice(w, h, 1'b1);
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_random_request(w, h, allow_total);
            queue_request(REQ_TOTAL, 0, 0, 1'b0);
            wait_for_drain();
            sender_idle = 1'b1;
        end

        if (mismatch_count == 0) begin
            $display("ising_lattice_energy_store_top verification clean");
        end else begin
            $display("ising_lattice_energy_store_top verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ile_pkg.sv
rtl/core/ile_spin_ram.sv
rtl/core/ile_seq.sv
rtl/core/ile_accum.sv
rtl/core/ising_lattice_energy_store_top.sv
bench/ising_lattice_energy_store_top_test.sv
